FILE: hdl/cpio_pkg.sv
// cpio newc deframer package: event and error codes, phase codes, queue entry type.
// Used by every module of the deframer; no dependencies.
package cpio_pkg;

  localparam int unsigned HeaderBytes     = 110;
  localparam int unsigned MaxArchiveBytes = 134217728;
  localparam int unsigned LenW            = 28;

  localparam logic [2:0] EV_NAME    = 3'd0;
  localparam logic [2:0] EV_ENTRY   = 3'd1;
  localparam logic [2:0] EV_PAYLOAD = 3'd2;
  localparam logic [2:0] EV_DONE    = 3'd3;
  localparam logic [2:0] EV_ERROR   = 3'd4;

  localparam logic [3:0] ERR_MAGIC      = 4'd0;
  localparam logic [3:0] ERR_HEX        = 4'd1;
  localparam logic [3:0] ERR_NAME_BOUND = 4'd2;
  localparam logic [3:0] ERR_UNTERM     = 4'd3;
  localparam logic [3:0] ERR_ALIGN      = 4'd4;
  localparam logic [3:0] ERR_PAYLOAD    = 4'd5;
  localparam logic [3:0] ERR_TRL_PAY    = 4'd6;
  localparam logic [3:0] ERR_UNSAFE     = 4'd7;
  localparam logic [3:0] ERR_TYPE       = 4'd8;
  localparam logic [3:0] ERR_NO_TRAILER = 4'd9;

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_NAME   = 7'b0000010,
    PH_PAD1   = 7'b0000100,
    PH_EMIT   = 7'b0001000,
    PH_PAD2   = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_SKIP   = 7'b1000000
  } phase_t;

  // One result, as carried from the parser to the output side.
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] mode_bits;
    logic [27:0] entry_size;
    logic        is_root;
    logic [3:0]  error_code;
    logic        last_of_run;
  } res_t;

  // Up to two results caused by one byte.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } pair_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
    return d;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] k);
    logic [7:0] c;
    case (k)
      4'd0: c = 8'h54; 4'd1: c = 8'h52; 4'd2: c = 8'h41; 4'd3: c = 8'h49;
      4'd4: c = 8'h4C; 4'd5: c = 8'h45; 4'd6: c = 8'h52; 4'd7: c = 8'h21;
      4'd8: c = 8'h21; 4'd9: c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] magic_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0: c = 8'h30; 3'd1: c = 8'h37; 3'd2: c = 8'h30;
      3'd3: c = 8'h37; 3'd4: c = 8'h30; 3'd5: c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/cpio_newc_stream_deframer.sv
// cpio newc stream deframer, top level: config register, parser, queue, output side.
// Depends on cpio_pkg, cpio_parse, cpio_queue, cpio_emit.
//
//  channel   handshake                 payload
//  input     archive_valid/stall       archive_byte
//  output    event_valid/stall         event_res data_byte mode_bits entry_size
//                                      is_root error_code last_of_run
//  config    cfg_valid/cfg_ready       cfg_data (archive_length)
//
// One byte per cycle while the queue is not full; the parser pushes the results of
// a byte in the cycle it accepts it, the output side moves one result per cycle unless
// stalled; the queue absorbs two-result bytes (payload alignment fault, archive end).
// Reset (rst, synchronous) clears the parser to header phase, empties the
// queue and sets archive_length to 1. Output stall backs up through the queue
// into archive_stall; the input is stalled only when the queue is full.
module cpio_newc_stream_deframer #(
  parameter int unsigned MAX_LEN     = cpio_pkg::MaxArchiveBytes,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [27:0] cfg_data,
  input  logic        archive_valid,
  output logic        archive_stall,
  input  logic [7:0]  archive_byte,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [15:0] mode_bits,
  output logic [27:0] entry_size,
  output logic        is_root,
  output logic [3:0]  error_code,
  output logic        last_of_run
);

  logic [27:0]     archive_length;
  logic            q_full, q_push, q_empty, q_pop;
  cpio_pkg::pair_t q_wdata, q_rdata;
  cpio_pkg::res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) archive_length <= 28'd1;
    else if (cfg_valid) archive_length <= cfg_data;
  end

  cpio_parse #(.MAX_LEN(MAX_LEN)) u_parse (
    .clk, .rst, .archive_length,
    .in_valid(archive_valid), .in_byte(archive_byte), .in_stall(archive_stall),
    .q_full, .q_push, .q_data(q_wdata)
  );

  cpio_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  cpio_emit u_emit (
    .clk, .rst, .q_empty, .q_data(q_rdata), .q_pop,
    .out_valid(event_valid), .out_stall(event_stall), .out_res(res)
  );

  assign event_res   = res.event_res;
  assign data_byte   = res.data_byte;
  assign mode_bits   = res.mode_bits;
  assign entry_size  = res.entry_size;
  assign is_root     = res.is_root;
  assign error_code  = res.error_code;
  assign last_of_run = res.last_of_run;

endmodule

FILE: hdl/cpio_parse.sv
// cpio deframer front part: accepts archive bytes, tracks header/name/payload
// phases and pushes the results of each byte (none, one or two) into the queue. Uses cpio_pkg.
module cpio_parse #(
  parameter int unsigned MAX_LEN = cpio_pkg::MaxArchiveBytes
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [cpio_pkg::LenW-1:0] archive_length,
  input  logic                     in_valid,
  input  logic [7:0]               in_byte,
  output logic                     in_stall,
  input  logic                     q_full,
  output logic                     q_push,
  output cpio_pkg::pair_t          q_data
);

  localparam logic [32:0] MaxLen = 33'(MAX_LEN);

  logic [27:0] stream_offset;
  cpio_pkg::phase_t phase;
  logic [6:0]  header_index;
  logic [15:0] mode_acc;
  logic [31:0] size_acc;
  logic [31:0] nlen_acc;
  logic [31:0] left;
  logic [1:0]  match;
  logic [2:0]  comp;
  logic        stopped;

  logic [27:0] stream_offset_next;
  cpio_pkg::phase_t phase_next;
  logic [6:0]  header_index_next;
  logic [15:0] mode_acc_next;
  logic [31:0] size_acc_next;
  logic [31:0] nlen_acc_next;
  logic [31:0] left_next;
  logic [1:0]  match_next;
  logic [2:0]  comp_next;
  logic        stopped_next;

  logic        take;
  assign in_stall = q_full;
  assign take = in_valid && !q_full;

  always_comb begin
    logic [32:0] len, off, pos, rem, aligned, pad;
    logic [4:0]  d;
    logic [31:0] k, left_dec;
    logic [1:0]  cs;
    logic        fail_now;
    logic [3:0]  code;
    logic        emit_ok;
    cpio_pkg::res_t a, b, e;

    stream_offset_next = stream_offset;
    phase_next = phase;
    header_index_next = header_index;
    mode_acc_next = mode_acc;
    size_acc_next = size_acc;
    nlen_acc_next = nlen_acc;
    left_next = left;
    match_next = match;
    comp_next = comp;
    stopped_next = stopped;
    fail_now = 1'b0;
    code = cpio_pkg::ERR_MAGIC;
    emit_ok = 1'b0;
    a = '0;
    e = '0;
    cs = comp[1:0];
    d = cpio_pkg::hex_digit(in_byte);
    k = nlen_acc - left;
    left_dec = left - 32'd1;

    len = ({5'd0, archive_length} > MaxLen) ? MaxLen : {5'd0, archive_length};
    off = {5'd0, stream_offset};
    pos = off + 33'd1;
    rem = len - off;
    aligned = (pos + 33'd3) & ~33'd3;
    pad = (33'd0 - pos) & 33'd3;

    if (off >= len) begin
      fail_now = 1'b1;
      code = cpio_pkg::ERR_NO_TRAILER;
    end else begin
      case (phase)
        cpio_pkg::PH_HEADER: begin
          if (header_index == 7'd0) begin
            mode_acc_next = '0;
            size_acc_next = '0;
            nlen_acc_next = '0;
          end
          if (header_index == 7'd0 && rem < 33'(cpio_pkg::HeaderBytes)) begin
            fail_now = 1'b1;
            code = cpio_pkg::ERR_MAGIC;
          end else if (header_index < 7'd6) begin
            if (in_byte != cpio_pkg::magic_char(header_index[2:0])) begin
              fail_now = 1'b1;
              code = cpio_pkg::ERR_MAGIC;
            end
          end else if ((header_index >= 7'd14 && header_index <= 7'd21) ||
                       (header_index >= 7'd54 && header_index <= 7'd61) ||
                       (header_index >= 7'd94 && header_index <= 7'd101)) begin
            if (d[4]) begin
              fail_now = 1'b1;
              code = cpio_pkg::ERR_HEX;
            end else if (header_index <= 7'd21) begin
              mode_acc_next = {mode_acc_next[11:0], d[3:0]};
            end else if (header_index <= 7'd61) begin
              size_acc_next = {size_acc_next[27:0], d[3:0]};
            end else begin
              nlen_acc_next = {nlen_acc_next[27:0], d[3:0]};
            end
          end
          if (!fail_now) begin
            if (header_index >= 7'(cpio_pkg::HeaderBytes - 1)) begin
              if (nlen_acc_next == 32'd0 || {1'b0, nlen_acc_next} > len - pos) begin
                fail_now = 1'b1;
                code = cpio_pkg::ERR_NAME_BOUND;
              end else begin
                phase_next = cpio_pkg::PH_NAME;
                left_next = nlen_acc_next;
                match_next = 2'b11;
                comp_next = 3'd0;
                header_index_next = 7'd0;
              end
            end else begin
              header_index_next = header_index + 7'd1;
            end
          end
        end
        cpio_pkg::PH_NAME: begin
          left_next = left_dec;
          if (left_dec != 32'd0) begin
            if (k >= 32'd10 || in_byte != cpio_pkg::trailer_char(k[3:0]))
              match_next[0] = 1'b0;
            if (k >= 32'd1 || in_byte != 8'h2E) match_next[1] = 1'b0;
            comp_next = comp;
            if (in_byte == 8'h2F) begin
              if (k == 32'd0 || cs == 2'd2) comp_next[2] = 1'b1;
              comp_next[1:0] = 2'd0;
            end else if (in_byte == 8'h2E) begin
              comp_next[1:0] = (cs == 2'd0) ? 2'd1 : (cs == 2'd1) ? 2'd2 : 2'd3;
            end else begin
              comp_next[1:0] = 2'd3;
            end
            emit_ok = 1'b1;
            a.event_res = cpio_pkg::EV_NAME;
            a.data_byte = in_byte;
          end else if (in_byte != 8'd0) begin
            fail_now = 1'b1; code = cpio_pkg::ERR_UNTERM;
          end else if (aligned > len) begin
            fail_now = 1'b1; code = cpio_pkg::ERR_ALIGN;
          end else if ({1'b0, size_acc} > len - aligned) begin
            fail_now = 1'b1; code = cpio_pkg::ERR_PAYLOAD;
          end else if (match[0] && nlen_acc == 32'd11) begin
            if (size_acc != 32'd0) begin
              fail_now = 1'b1; code = cpio_pkg::ERR_TRL_PAY;
            end else begin
              emit_ok = 1'b1;
              a.event_res = cpio_pkg::EV_DONE;
              phase_next = cpio_pkg::PH_DONE;
              stopped_next = 1'b1;
            end
          end else if (nlen_acc == 32'd1 || comp[2] || comp[1:0] == 2'd2) begin
            fail_now = 1'b1; code = cpio_pkg::ERR_UNSAFE;
          end else if (mode_acc[15:12] != 4'h4 && mode_acc[15:12] != 4'h8) begin
            fail_now = 1'b1; code = cpio_pkg::ERR_TYPE;
          end else begin
            emit_ok = 1'b1;
            a.event_res = cpio_pkg::EV_ENTRY;
            a.mode_bits = mode_acc;
            a.entry_size = size_acc[27:0];
            a.is_root = match[1] && nlen_acc == 32'd2;
            if (aligned > pos) begin
              phase_next = cpio_pkg::PH_PAD1;
              left_next = 32'(aligned - pos);
            end else if (size_acc != 32'd0) begin
              phase_next = (mode_acc[15:12] == 4'h8) ? cpio_pkg::PH_EMIT : cpio_pkg::PH_SKIP;
              left_next = size_acc;
            end else if (pos + pad > len) begin
              fail_now = 1'b1; code = cpio_pkg::ERR_ALIGN;
            end else if (pad != 33'd0) begin
              phase_next = cpio_pkg::PH_PAD2;
              left_next = 32'(pad);
            end else begin
              phase_next = cpio_pkg::PH_HEADER;
              header_index_next = 7'd0;
            end
          end
        end
        cpio_pkg::PH_PAD1: begin
          left_next = left_dec;
          if (left_dec == 32'd0) begin
            if (size_acc != 32'd0) begin
              phase_next = (mode_acc[15:12] == 4'h8) ? cpio_pkg::PH_EMIT : cpio_pkg::PH_SKIP;
              left_next = size_acc;
            end else if (pos + pad > len) begin
              fail_now = 1'b1; code = cpio_pkg::ERR_ALIGN;
            end else if (pad != 33'd0) begin
              phase_next = cpio_pkg::PH_PAD2;
              left_next = 32'(pad);
            end else begin
              phase_next = cpio_pkg::PH_HEADER;
              header_index_next = 7'd0;
            end
          end
        end
        cpio_pkg::PH_EMIT, cpio_pkg::PH_SKIP: begin
          if (phase == cpio_pkg::PH_EMIT) begin
            emit_ok = 1'b1;
            a.event_res = cpio_pkg::EV_PAYLOAD;
            a.data_byte = in_byte;
          end
          left_next = left_dec;
          if (left_dec == 32'd0) begin
            if (pos + pad > len) begin
              fail_now = 1'b1; code = cpio_pkg::ERR_ALIGN;
            end else if (pad != 33'd0) begin
              phase_next = cpio_pkg::PH_PAD2;
              left_next = 32'(pad);
            end else begin
              phase_next = cpio_pkg::PH_HEADER;
              header_index_next = 7'd0;
            end
          end
        end
        cpio_pkg::PH_PAD2: begin
          left_next = left_dec;
          if (left_dec == 32'd0) begin
            phase_next = cpio_pkg::PH_HEADER;
            header_index_next = 7'd0;
          end
        end
        default: stopped_next = 1'b1;
      endcase
      stream_offset_next = pos[27:0];
    end

    if (fail_now) stopped_next = 1'b1;
    // end-of-archive check once the byte is done
    if (off < len && !stopped_next && phase_next == cpio_pkg::PH_HEADER &&
        header_index_next == 7'd0 && pos == len) begin
      fail_now = 1'b1;
      code = cpio_pkg::ERR_NO_TRAILER;
      stopped_next = 1'b1;
    end

    e.event_res = cpio_pkg::EV_ERROR;
    e.error_code = code;
    b = e;
    q_data = '0;
    if (emit_ok && fail_now) begin
      q_data.count = 2'd2;
      q_data.r0 = a;
      b.last_of_run = 1'b1;
      q_data.r1 = b;
    end else if (emit_ok) begin
      q_data.count = 2'd1;
      a.last_of_run = 1'b1;
      q_data.r0 = a;
    end else if (fail_now) begin
      q_data.count = 2'd1;
      b.last_of_run = 1'b1;
      q_data.r0 = b;
    end
    q_push = take && !stopped && q_data.count != 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_offset <= '0;
      phase <= cpio_pkg::PH_HEADER;
      header_index <= '0;
      mode_acc <= '0;
      size_acc <= '0;
      nlen_acc <= '0;
      left <= '0;
      match <= 2'b11;
      comp <= '0;
      stopped <= 1'b0;
    end else if (take && !stopped) begin
      stream_offset <= stream_offset_next;
      phase <= phase_next;
      header_index <= header_index_next;
      mode_acc <= mode_acc_next;
      size_acc <= size_acc_next;
      nlen_acc <= nlen_acc_next;
      left <= left_next;
      match <= match_next;
      comp <= comp_next;
      stopped <= stopped_next;
    end
  end

endmodule

FILE: hdl/cpio_queue.sv
// cpio deframer queue between parser and output side; holds result pairs.
// Uses cpio_pkg.
module cpio_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cpio_pkg::pair_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output cpio_pkg::pair_t rdata
);

  localparam int unsigned AW = $clog2(DEPTH);

  cpio_pkg::pair_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   cnt;

  assign full  = cnt == (AW+1)'(DEPTH);
  assign empty = cnt == '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (pop && !empty) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      cnt <= cnt + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule

FILE: hdl/cpio_emit.sv
// cpio deframer back part: drains result pairs from the queue and presents
// them one per transfer on the output registers. Uses cpio_pkg.
module cpio_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  cpio_pkg::pair_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output cpio_pkg::res_t  out_res
);

  logic sel;        // which result of the head pair goes next
  logic load;

  assign load  = !q_empty && (!out_valid || !out_stall);
  assign q_pop = load && (sel || q_data.count == 2'd1);

  always_ff @(posedge clk) begin
    if (load) out_res <= sel ? q_data.r1 : q_data.r0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (load) sel <= !q_pop;
    end
  end

endmodule

FILE: bench/tb_cpio_newc_stream_deframer.sv
// Testbench for cpio_newc_stream_deframer: streams a generated newc archive, predicts events.
// Depends on cpio_pkg (event/error codes, phase_t, res_t) and the deframer RTL.

// Deframe prediction and the queue of events still owed by the block.
class cpio_scoreboard;
  cpio_pkg::res_t   owed[$];
  int unsigned      fails;
  longint unsigned  arch_len;
  int unsigned      offset, hdr_idx, mode_acc, size_acc, nlen_acc, left;
  bit [1:0]         match;     // bit0 trailer prefix, bit1 single dot
  bit [2:0]         comp;      // [2] unsafe seen, [1:0] component state
  bit               halted;
  cpio_pkg::phase_t ph;

  function new();
    arch_len = 1;
    ph       = cpio_pkg::PH_HEADER;
    match    = 2'b11;
  endfunction

  function void push(logic [2:0] ev, logic [7:0] d, logic [15:0] m, logic [27:0] s,
                     logic root, logic [3:0] err);
    cpio_pkg::res_t r;
    r = '{event_res: ev, data_byte: d, mode_bits: m, entry_size: s,
          is_root: root, error_code: err, last_of_run: 1'b0};
    owed.insert(owed.size(), r);
  endfunction

  function void raise(logic [3:0] err);
    halted = 1;
    push(cpio_pkg::EV_ERROR, 0, 0, 0, 0, err);
  endfunction

  // Payload ended at pos; returns 0 when its padding would run past the end.
  function bit close_payload(longint unsigned pos, longint unsigned len);
    longint unsigned pad;
    pad = (4 - (pos & 3)) & 3;
    if (pos + pad > len) return 0;
    if (pad != 0) begin
      ph = cpio_pkg::PH_PAD2;
      left = 32'(pad);
    end else begin
      ph = cpio_pkg::PH_HEADER;
      hdr_idx = 0;
    end
    return 1;
  endfunction

  function bit open_payload(longint unsigned pos, longint unsigned len);
    if (size_acc != 0) begin
      ph = ((mode_acc & 16'hF000) == 16'h8000) ? cpio_pkg::PH_EMIT : cpio_pkg::PH_SKIP;
      left = size_acc;
      return 1;
    end
    return close_payload(pos, len);
  endfunction

  function int unsigned hex_val(bit [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  // One accepted archive byte: append the events it causes.
  function void note(bit [7:0] b);
    string           trl, mg;
    int              start;
    longint unsigned len, pos, aligned;
    int unsigned     d, k, nl, cs;
    bit              unsafe;
    trl = "TRAILER!!!";
    mg = "070701";
    if (halted) return;
    start = owed.size();
    len = (arch_len > cpio_pkg::MaxArchiveBytes) ? cpio_pkg::MaxArchiveBytes : arch_len;
    if (offset >= len) begin
      raise(cpio_pkg::ERR_NO_TRAILER);
      owed[owed.size()-1].last_of_run = 1;
      return;
    end
    pos = offset + 1;
    case (ph)
      cpio_pkg::PH_HEADER: begin : hdr
        if (hdr_idx == 0) begin
          if (len - offset < cpio_pkg::HeaderBytes) begin
            raise(cpio_pkg::ERR_MAGIC);
            disable hdr;
          end
          mode_acc = 0;
          size_acc = 0;
          nlen_acc = 0;
        end
        if (hdr_idx < 6) begin
          if (b != mg[hdr_idx]) begin
            raise(cpio_pkg::ERR_MAGIC);
            disable hdr;
          end
        end else if ((hdr_idx >= 14 && hdr_idx <= 21) || (hdr_idx >= 54 && hdr_idx <= 61) ||
                     (hdr_idx >= 94 && hdr_idx <= 101)) begin
          d = hex_val(b);
          if (d > 15) begin
            raise(cpio_pkg::ERR_HEX);
            disable hdr;
          end
          if (hdr_idx <= 21) mode_acc = ((mode_acc << 4) | d) & 16'hFFFF;
          else if (hdr_idx <= 61) size_acc = (size_acc << 4) | d;
          else nlen_acc = (nlen_acc << 4) | d;
        end
        if (hdr_idx >= cpio_pkg::HeaderBytes - 1) begin
          if (nlen_acc == 0 || longint'(nlen_acc) > len - pos) begin
            raise(cpio_pkg::ERR_NAME_BOUND);
            disable hdr;
          end
          ph = cpio_pkg::PH_NAME;
          left = nlen_acc;
          match = 2'b11;
          comp = 0;
          hdr_idx = 0;
        end else begin
          hdr_idx++;
        end
      end
      cpio_pkg::PH_NAME: begin : nm
        k = nlen_acc - left;
        nl = nlen_acc;
        left--;
        if (left != 0) begin
          cs = comp[1:0];
          if (k >= 10 || b != trl[k]) match[0] = 0;
          if (k >= 1 || b != ".") match[1] = 0;
          if (b == "/") begin
            if (k == 0 || cs == 2) comp[2] = 1;
            cs = 0;
          end else if (b == ".") begin
            cs = (cs == 0) ? 1 : (cs == 1) ? 2 : 3;
          end else begin
            cs = 3;
          end
          comp[1:0] = 2'(cs);
          push(cpio_pkg::EV_NAME, b, 0, 0, 0, 0);
          disable nm;
        end
        if (b != 0) begin
          raise(cpio_pkg::ERR_UNTERM);
          disable nm;
        end
        aligned = (pos + 3) & ~longint'(3);
        if (aligned > len) begin
          raise(cpio_pkg::ERR_ALIGN);
          disable nm;
        end
        if (longint'(size_acc) > len - aligned) begin
          raise(cpio_pkg::ERR_PAYLOAD);
          disable nm;
        end
        if (match[0] && nl == 11) begin
          if (size_acc != 0) begin
            raise(cpio_pkg::ERR_TRL_PAY);
            disable nm;
          end
          push(cpio_pkg::EV_DONE, 0, 0, 0, 0, 0);
          ph = cpio_pkg::PH_DONE;
          halted = 1;
          disable nm;
        end
        unsafe = nl == 1 || comp[2] || comp[1:0] == 2;
        if (unsafe) begin
          raise(cpio_pkg::ERR_UNSAFE);
          disable nm;
        end
        if ((mode_acc & 16'hF000) != 16'h4000 && (mode_acc & 16'hF000) != 16'h8000) begin
          raise(cpio_pkg::ERR_TYPE);
          disable nm;
        end
        push(cpio_pkg::EV_ENTRY, 0, 16'(mode_acc), 28'(size_acc), match[1] && nl == 2, 0);
        if (aligned > pos) begin
          ph = cpio_pkg::PH_PAD1;
          left = 32'(aligned - pos);
        end else if (!open_payload(pos, len)) begin
          raise(cpio_pkg::ERR_ALIGN);
        end
      end
      cpio_pkg::PH_PAD1: begin
        left--;
        if (left == 0 && !open_payload(pos, len)) raise(cpio_pkg::ERR_ALIGN);
      end
      cpio_pkg::PH_EMIT, cpio_pkg::PH_SKIP: begin
        if (ph == cpio_pkg::PH_EMIT) push(cpio_pkg::EV_PAYLOAD, b, 0, 0, 0, 0);
        left--;
        if (left == 0 && !close_payload(pos, len)) raise(cpio_pkg::ERR_ALIGN);
      end
      cpio_pkg::PH_PAD2: begin
        left--;
        if (left == 0) begin
          ph = cpio_pkg::PH_HEADER;
          hdr_idx = 0;
        end
      end
      default: halted = 1;
    endcase
    offset = 32'(pos & 28'hFFFFFFF);
    if (!halted && ph == cpio_pkg::PH_HEADER && hdr_idx == 0 && pos == len)
      raise(cpio_pkg::ERR_NO_TRAILER);
    if (owed.size() > start) owed[owed.size()-1].last_of_run = 1;
  endfunction

  function void check(cpio_pkg::res_t got);
    cpio_pkg::res_t want;
    if (owed.size() == 0) begin
      $display("%0t: unexpected event, expected none, got %p", $time, got);
      fails++;
      return;
    end
    want = owed.pop_front();
    if (want !== got) begin
      $display("%0t: event mismatch, expected %p, got %p", $time, want, got);
      fails++;
    end
  endfunction
endclass

module tb_cpio_newc_stream_deframer;
  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [27:0] cfg_data = 0;
  logic        archive_valid = 0;
  logic        archive_stall;
  logic [7:0]  archive_byte = 0;
  logic        event_valid;
  logic        event_stall = 0;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [15:0] mode_bits;
  logic [27:0] entry_size;
  logic        is_root;
  logic [3:0]  error_code;
  logic        last_of_run;

  cpio_scoreboard sb = new();
  bit [7:0]       arch[$];     // archive image to stream
  int unsigned    body_len;    // bytes up to the end of the last real entry
  int unsigned    send_idle, recv_stall;
  int unsigned    cycles;

  cpio_newc_stream_deframer i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .archive_valid(archive_valid), .archive_stall(archive_stall),
    .archive_byte(archive_byte),
    .event_valid(event_valid), .event_stall(event_stall),
    .event_res(event_res), .data_byte(data_byte), .mode_bits(mode_bits),
    .entry_size(entry_size), .is_root(is_root), .error_code(error_code),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watchdog: generous against a fully stalled, two-event-per-byte run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver backpressure, changed on the falling edge.
  always @(negedge clk) event_stall <= ($urandom_range(0, 99) < recv_stall);

  // Every transfer on the event side is checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && event_valid && !event_stall)
      sb.check('{event_res: event_res, data_byte: data_byte, mode_bits: mode_bits,
                 entry_size: entry_size, is_root: is_root, error_code: error_code,
                 last_of_run: last_of_run});
  end

  // Append one byte to the archive image.
  task put_byte(input int unsigned v);
    arch.insert(arch.size(), 8'(v));
  endtask

  // Hex text of a 32-bit field, letters in random case.
  task put_hex(input int unsigned v);
    int unsigned n;
    for (int i = 7; i >= 0; i--) begin
      n = (v >> (4 * i)) & 4'hF;
      if (n < 10) put_byte("0" + n);
      else put_byte(($urandom_range(0, 1) ? "a" : "A") + n - 10);
    end
  endtask

  // Append a full entry: header, name plus terminator, padding, payload, padding.
  task add_entry(input int unsigned mode, input bit [7:0] nm[$], input int unsigned size);
    string mg;
    mg = "070701";
    for (int i = 0; i < 6; i++) put_byte(mg[i]);
    repeat (8) put_byte($urandom_range(0, 255));   // ino, never parsed
    put_hex(mode);
    repeat (32) put_byte($urandom_range(0, 255));  // uid..mtime
    put_hex(size);
    repeat (32) put_byte($urandom_range(0, 255));  // dev fields
    put_hex(nm.size() + 1);
    repeat (8) put_byte($urandom_range(0, 255));   // check field
    foreach (nm[i]) put_byte(nm[i]);
    put_byte(0);
    while (arch.size() % 4) put_byte($urandom_range(0, 255));
    repeat (size) put_byte($urandom_range(0, 255));
    while (arch.size() % 4) put_byte($urandom_range(0, 255));
  endtask

  // Safe path: components of random bytes, no '/' inside, never exactly "..".
  function void random_name(output bit [7:0] nm[$]);
    int unsigned parts, clen;
    bit [7:0]    c;
    nm = {};
    parts = $urandom_range(1, 3);
    for (int p = 0; p < parts; p++) begin
      if (p != 0) nm.insert(nm.size(), "/");
      clen = $urandom_range(1, 4);
      for (int i = 0; i < clen; i++) begin
        case ($urandom_range(0, 5))
          0: c = ".";
          1: c = 0;
          default: c = 8'($urandom_range(0, 255));
        endcase
        if (c == "/") c = "q";
        if (i == 1 && clen == 2 && c == "." && nm[nm.size()-1] == ".") c = "z";
        nm.insert(nm.size(), c);
      end
    end
  endfunction

  function int unsigned random_mode(bit dir);
    return ($urandom() & 32'hFFFF0FFF) | (dir ? 32'h4000 : 32'h8000);
  endfunction

  task write_length(input logic [27:0] v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.arch_len = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Hold the sender until every owed event is out, then let the parser settle.
  task drain();
    archive_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task send_byte(input bit [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      archive_valid <= 0;
      @(negedge clk);
    end
    archive_valid <= 1;
    archive_byte  <= b;
    do @(posedge clk); while (archive_stall);
    sb.note(b);
    @(negedge clk);
  endtask

  initial begin
    bit [7:0]    nm[$];
    int unsigned sz, ending, third;

    // Directed opening: root dir, dir with skipped payload, empty file,
    // name with embedded zero, all-ones permission and upper mode bits.
    add_entry(32'h000041ED, '{"."}, 0);
    add_entry(32'h000041FF, '{"d", "i", "r"}, 5);
    add_entry(32'h000081A4, '{".", "/", "e"}, 0);
    add_entry(32'h00008000, '{"a", 8'h00, "b", "/", ".", "x"}, 3);
    add_entry(32'hFFFF8FFF, '{8'hFF, "/", "."}, 1);
    // Random entries, mostly small payloads, the odd larger one.
    while (arch.size() < 480) begin
      random_name(nm);
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      add_entry(random_mode($urandom_range(0, 3) == 0), nm, sz);
    end
    // Archive end: proper trailer, missing trailer, or an unsafe path.
    ending = $urandom_range(0, 3);
    if (ending == 2) begin
      body_len = arch.size();
    end else if (ending == 3) begin
      add_entry(random_mode(0), '{"a", "/", ".", ".", "/", "b"}, 2);
      body_len = arch.size();
    end else begin
      add_entry(0, '{"T", "R", "A", "I", "L", "E", "R", "!", "!", "!"}, 0);
      body_len = arch.size();
    end
    repeat ($urandom_range(0, 8)) put_byte($urandom_range(0, 255));  // ignored tail

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    write_length(28'd1);
    write_length(28'hFFFFFFF);   // above the cap, clamps to 128 MiB
    third = arch.size() / 3;
    send_idle  = 22;
    recv_stall = 62;
    for (int i = 0; i < arch.size(); i++) begin
      if (i == third) begin
        drain();
        write_length(28'(cpio_pkg::MaxArchiveBytes));
        send_idle  = 62;
        recv_stall = 22;
      end else if (i == 2 * third) begin
        drain();
        write_length(28'(body_len));  // exact end from here on
        send_idle  = 0;
        recv_stall = 0;
      end
      send_byte(arch[i]);
    end
    drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.owed.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/cpio_pkg.sv
hdl/cpio_parse.sv
hdl/cpio_queue.sv
hdl/cpio_emit.sv
hdl/cpio_newc_stream_deframer.sv
bench/tb_cpio_newc_stream_deframer.sv
